// ===== hdl/gte_pkg.sv =====
// Shared types, constants and a helper function of the geodetic to ECEF surface unit.
package gte_pkg;

   // Fixed-point constants (Q31 unless noted; OUT_LIMIT is Q8, QUARTER_TURN a binary angle)
   localparam logic [32:0]        PI_Q31           = 33'd6746518852;
   localparam logic [23:0]        E2_Q31           = 24'd14376072;
   localparam logic [30:0]        ONE_MINUS_E2_Q31 = 31'd2133107576;
   localparam logic [30:0]        SEMI_MAJOR_Q8    = 31'd1632803072;
   localparam logic [31:0]        OUT_LIMIT        = 32'd1632803072;
   localparam logic [31:0]        Q31_ONE          = 32'h8000_0000;
   localparam logic [63:0]        ROUND_Q31        = 64'd1073741824;
   localparam logic signed [31:0] QUARTER_TURN     = 32'sd1073741824;

   // Pipeline geometry
   localparam int TERM_COUNT  = 6;
   localparam int TRIG_STAGES = 5 + 3 * TERM_COUNT + 1;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 31;
   localparam int POST_STAGES = 3 + SQRT_STEPS + DIV_STEPS + 4;
   localparam int PASS_LEN    = 3 + SQRT_STEPS + DIV_STEPS + 2;
   localparam int PIPE_DEPTH  = 1 + TRIG_STAGES + POST_STAGES;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } gte_quad_type;

   typedef struct packed {
      gte_quad_type quad;
      logic         swap;
   } gte_ctl_type;

   typedef struct packed {
      gte_ctl_type ctl;
      logic [30:0] x2;
   } gte_side_type;

   typedef struct packed {
      logic signed [32:0] slat;
      logic signed [32:0] clat;
      logic signed [32:0] slon;
      logic signed [32:0] clon;
   } gte_pass_type;

   // Divisor of Taylor term n: chain 0 is sine, chain 1 is cosine
   function automatic int term_divisor(input int chain, input int n);
      int d;
      if (chain == 0) begin
         d = (2 * n) * (2 * n + 1);
      end else begin
         d = (2 * n - 1) * (2 * n);
      end
      return d;
   endfunction

endpackage

// ===== hdl/gte_trig.sv =====
// Pipelined Q31 sine and cosine of a 32-bit binary angle.
module gte_trig (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        angle,
   output logic               out_valid,
   output logic signed [32:0] sin_out,
   output logic signed [32:0] cos_out
);
   import gte_pkg::*;

   function automatic logic [31:0] clamp_q31(input logic signed [33:0] v);
      logic [31:0] r;
      if (v < 34'sd0) begin
         r = 32'd0;
      end else if (v > $signed({2'b00, Q31_ONE})) begin
         r = Q31_ONE;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [TRIG_STAGES-1:0] vld_ff;

   logic [29:0] r_raw;
   logic [29:0] rr_in;
   logic        swap_in;

   logic [29:0]  rr_a_ff;
   gte_ctl_type  ctl_a_ff;
   logic [62:0]  prod_pi_ff;
   gte_ctl_type  ctl_b_ff;
   logic [30:0]  x_c_ff;
   gte_ctl_type  ctl_c_ff;
   logic [61:0]  xsq_d_ff;
   logic [30:0]  x_d_ff;
   gte_ctl_type  ctl_d_ff;
   logic [30:0]  x2_in;

   gte_side_type       side_ff    [0:TERM_COUNT];
   gte_side_type       side_s1_ff [1:TERM_COUNT];
   gte_side_type       side_s2_ff [1:TERM_COUNT];
   logic [31:0]        t_ff       [0:1][0:TERM_COUNT];
   logic signed [33:0] acc_ff     [0:1][0:TERM_COUNT];
   logic signed [33:0] acc_s1_ff  [0:1][1:TERM_COUNT];
   logic signed [33:0] acc_s2_ff  [0:1][1:TERM_COUNT];
   logic [62:0]        prod_ff    [0:1][1:TERM_COUNT];
   logic [31:0]        p_ff       [0:1][1:TERM_COUNT];
   logic [63:0]        m_ff       [0:1][1:TERM_COUNT];

   logic [31:0]        s_mag;
   logic [31:0]        c_mag;
   logic [31:0]        bs;
   logic [31:0]        bc;
   logic signed [32:0] sin_in;
   logic signed [32:0] cos_in;
   logic signed [32:0] sin_ff;
   logic signed [32:0] cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TRIG_STAGES-2:0], in_valid};
      end
   end

   // Fold the quarter turn into [0, pi/4]
   assign r_raw = angle[29:0];

   always_comb begin
      if (r_raw <= 30'h2000_0000) begin
         rr_in   = r_raw;
         swap_in = 1'b0;
      end else begin
         rr_in   = 30'd0 - r_raw;
         swap_in = 1'b1;
      end
   end

   assign x2_in = 31'((64'(xsq_d_ff) + ROUND_Q31) >> 31);

   always_ff @(posedge clock) begin
      rr_a_ff       <= rr_in;
      ctl_a_ff.quad <= gte_quad_type'(angle[31:30]);
      ctl_a_ff.swap <= swap_in;
      prod_pi_ff    <= 63'(rr_a_ff) * 63'(PI_Q31);
      ctl_b_ff      <= ctl_a_ff;
      x_c_ff        <= 31'((prod_pi_ff + 63'(ROUND_Q31)) >> 31);
      ctl_c_ff      <= ctl_b_ff;
      xsq_d_ff      <= 62'(x_c_ff) * 62'(x_c_ff);
      x_d_ff        <= x_c_ff;
      ctl_d_ff      <= ctl_c_ff;
      side_ff[0]    <= '{ctl: ctl_d_ff, x2: x2_in};
      t_ff[0][0]    <= {1'b0, x_d_ff};
      acc_ff[0][0]  <= $signed({3'b000, x_d_ff});
      t_ff[1][0]    <= Q31_ONE;
      acc_ff[1][0]  <= $signed({2'b00, Q31_ONE});
   end

   // Taylor terms: product, reciprocal multiply, correct and accumulate
   genvar gn, gc;
   for (gn = 1; gn <= TERM_COUNT; gn++) begin : g_term
      always_ff @(posedge clock) begin
         side_s1_ff[gn] <= side_ff[gn-1];
         side_s2_ff[gn] <= side_s1_ff[gn];
         side_ff[gn]    <= side_s2_ff[gn];
      end

      for (gc = 0; gc < 2; gc++) begin : g_chain
         localparam int          K        = term_divisor(gc, gn);
         localparam logic [31:0] Recip    = 32'((64'd1 << 32) / K);
         localparam bit          Subtract = (gn % 2) == 1;

         if (gc == 1 || gn < TERM_COUNT) begin : g_active
            logic [31:0]        p_in;
            logic [31:0]        q0;
            logic [39:0]        rem;
            logic [31:0]        t_in;
            logic signed [33:0] acc_in;

            always_comb begin
               p_in = 32'((prod_ff[gc][gn] + 63'(ROUND_Q31)) >> 31);
               q0   = m_ff[gc][gn][63:32];
               rem  = 40'(p_ff[gc][gn]) - 40'(q0) * 40'(K);
               t_in = (rem >= 40'(K)) ? q0 + 32'd1 : q0;
               if (Subtract) begin
                  acc_in = acc_s2_ff[gc][gn] - $signed({2'b00, t_in});
               end else begin
                  acc_in = acc_s2_ff[gc][gn] + $signed({2'b00, t_in});
               end
            end

            always_ff @(posedge clock) begin
               prod_ff[gc][gn]   <= 63'(t_ff[gc][gn-1]) * 63'(side_ff[gn-1].x2);
               acc_s1_ff[gc][gn] <= acc_ff[gc][gn-1];
               p_ff[gc][gn]      <= p_in;
               m_ff[gc][gn]      <= 64'(p_in) * 64'(Recip);
               acc_s2_ff[gc][gn] <= acc_s1_ff[gc][gn];
               t_ff[gc][gn]      <= t_in;
               acc_ff[gc][gn]    <= acc_in;
            end
         end else begin : g_hold
            always_ff @(posedge clock) begin
               acc_s1_ff[gc][gn] <= acc_ff[gc][gn-1];
               acc_s2_ff[gc][gn] <= acc_s1_ff[gc][gn];
               acc_ff[gc][gn]    <= acc_s2_ff[gc][gn];
            end
         end
      end
   end

   // Clamp, undo the fold and apply the quadrant
   always_comb begin
      s_mag = clamp_q31(acc_ff[0][TERM_COUNT]);
      c_mag = clamp_q31(acc_ff[1][TERM_COUNT]);
      if (side_ff[TERM_COUNT].ctl.swap) begin
         bs = c_mag;
         bc = s_mag;
      end else begin
         bs = s_mag;
         bc = c_mag;
      end
      case (side_ff[TERM_COUNT].ctl.quad)
         QUAD_0: begin
            sin_in = $signed({1'b0, bs});
            cos_in = $signed({1'b0, bc});
         end
         QUAD_1: begin
            sin_in = $signed({1'b0, bc});
            cos_in = -$signed({1'b0, bs});
         end
         QUAD_2: begin
            sin_in = -$signed({1'b0, bs});
            cos_in = -$signed({1'b0, bc});
         end
         default: begin
            sin_in = -$signed({1'b0, bc});
            cos_in = $signed({1'b0, bs});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign out_valid = vld_ff[TRIG_STAGES-1];
   assign sin_out   = sin_ff;
   assign cos_out   = cos_ff;

endmodule

// ===== hdl/geodetic_to_ecef_surface_unit.sv =====
// Top level: WGS84 geodetic latitude and longitude to ECEF surface point.
//
// Usage
//  - Input channel: drive req_latitude (signed binary angle, 2^31 = pi) and
//    req_longitude (unsigned binary angle, 2^32 = two pi) with start high;
//    the item is taken at a rising edge where start is high and busy is low.
//  - Result channel: rsp_pos_x/y/z (metres, signed Q23.8) are shown for one
//    cycle with rsp_strobe high. The receiver cannot hold results off.
//  - Throughput: one item every cycle, indefinitely, while busy is low.
//  - The pipeline is built of 1 input stage, 24 stages of sine and
//    cosine (5 to scale and square the angle and seed the series, six Taylor
//    terms at three stages each, 1 to apply the quadrant), 3 stages for
//    1 - e2 sin^2, 32 one-digit square-root stages, 31 one-bit divider stages
//    for the prime vertical radius and 4 product stages.
//  - Reset (synchronous, active high) drops every item in flight; busy is a
//    registered copy of reset: high in the cycle after each reset cycle, else low.
//  - Latitude beyond plus or minus pi/2 is clamped; coordinates saturate
//    to plus or minus the semi-major axis.
module geodetic_to_ecef_surface_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_latitude,
   input  logic [31:0]        req_longitude,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);
   import gte_pkg::*;

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return (v < 33'sd0) ? n[31:0] : v[31:0];
   endfunction

   function automatic logic signed [31:0] round_sat(input logic [62:0] prod, input logic neg);
      logic [31:0] r;
      r = 32'((prod + 63'(ROUND_Q31)) >> 31);
      if (r > OUT_LIMIT) begin
         r = OUT_LIMIT;
      end
      return neg ? -$signed(r) : $signed(r);
   endfunction

   logic busy_ff;

   // Input stage
   logic               in_vld_ff;
   logic signed [31:0] lat_in;
   logic signed [31:0] lat_ff;
   logic [31:0]        lon_ff;

   // Trig results
   logic               trig_vld;
   logic signed [32:0] slat;
   logic signed [32:0] clat;
   logic signed [32:0] slon;
   logic signed [32:0] clon;

   logic [POST_STAGES-1:0] post_vld_ff;
   gte_pass_type           pass_ff [0:PASS_LEN-1];

   // 1 - e2 sin^2
   logic [63:0] s2prod_ff;
   logic [31:0] s2_in;
   logic [55:0] e2prod_ff;
   logic [31:0] w_ff;

   // Square root and divider stages
   logic [33:0] sq_rem_ff  [1:SQRT_STEPS];
   logic [31:0] sq_root_ff [1:SQRT_STEPS];
   logic [31:0] sq_w_ff    [1:SQRT_STEPS];
   logic [31:0] dv_rem_ff  [1:DIV_STEPS];
   logic [30:0] dv_quo_ff  [1:DIV_STEPS];
   logic [31:0] dv_d_ff    [1:DIV_STEPS];

   // Products
   logic [62:0] ncl_prod_ff;
   logic        ncl_neg_ff;
   logic [61:0] zr_prod_ff;
   logic [31:0] ncl_mag_ff;
   logic        ncl_neg2_ff;
   logic [30:0] nz_ff;
   logic [62:0] x_prod_ff;
   logic [62:0] y_prod_ff;
   logic [62:0] z_prod_ff;
   logic        x_neg_ff;
   logic        y_neg_ff;
   logic        z_neg_ff;
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic signed [31:0] pos_z_ff;

   // Hold off new items during reset and the cycle after
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // Clamp latitude to the poles
   always_comb begin
      if (req_latitude > QUARTER_TURN) begin
         lat_in = QUARTER_TURN;
      end else if (req_latitude < -QUARTER_TURN) begin
         lat_in = -QUARTER_TURN;
      end else begin
         lat_in = req_latitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start & ~busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      lat_ff <= lat_in;
      lon_ff <= req_longitude;
   end

   gte_trig u_trig_lat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .angle     ($unsigned(lat_ff)),
      .out_valid (trig_vld),
      .sin_out   (slat),
      .cos_out   (clat)
   );

   gte_trig u_trig_lon (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_vld_ff),
      .angle     (lon_ff),
      .out_valid (),
      .sin_out   (slon),
      .cos_out   (clon)
   );

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else begin
         post_vld_ff <= {post_vld_ff[POST_STAGES-2:0], trig_vld};
      end
   end

   // Carry the trig results past the radius computation
   always_ff @(posedge clock) begin
      pass_ff[0] <= '{slat: slat, clat: clat, slon: slon, clon: clon};
      for (int i = 1; i < PASS_LEN; i++) begin
         pass_ff[i] <= pass_ff[i-1];
      end
   end

   // sin^2 lat, then w = 1 - e2 sin^2 lat
   assign s2_in = 32'((s2prod_ff + ROUND_Q31) >> 31);

   always_ff @(posedge clock) begin
      s2prod_ff <= 64'(mag33(slat)) * 64'(mag33(slat));
      e2prod_ff <= 56'(E2_Q31) * 56'(s2_in);
      w_ff      <= Q31_ONE - 32'((64'(e2prod_ff) + ROUND_Q31) >> 31);
   end

   // Square root of w << 31, one root digit per stage
   genvar gj;
   for (gj = 0; gj < SQRT_STEPS; gj++) begin : g_sqrt
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [31:0] w_prev;
      logic [63:0] v64;
      logic [35:0] rem_sh;
      logic [35:0] trial;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      if (gj == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign w_prev    = w_ff;
      end else begin : g_next
         assign rem_prev  = sq_rem_ff[gj];
         assign root_prev = sq_root_ff[gj];
         assign w_prev    = sq_w_ff[gj];
      end

      always_comb begin
         v64    = {1'b0, w_prev, 31'd0};
         rem_sh = {rem_prev, v64[63-2*gj -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         sq_rem_ff[gj+1]  <= rem_in;
         sq_root_ff[gj+1] <= root_in;
         sq_w_ff[gj+1]    <= w_prev;
      end
   end

   // N = (a << 31 + sq/2) / sq, one quotient bit per stage
   genvar gi;
   for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
      logic [31:0] rem_prev;
      logic [30:0] quo_prev;
      logic [31:0] d_prev;
      logic [32:0] rem_sh;
      logic [31:0] rem_in;
      logic        qbit;

      if (gi == 0) begin : g_first
         assign rem_prev = {1'b0, SEMI_MAJOR_Q8};
         assign quo_prev = '0;
         assign d_prev   = sq_root_ff[SQRT_STEPS];
      end else begin : g_next
         assign rem_prev = dv_rem_ff[gi];
         assign quo_prev = dv_quo_ff[gi];
         assign d_prev   = dv_d_ff[gi];
      end

      always_comb begin
         rem_sh = {rem_prev, d_prev[31-gi]};
         if (rem_sh >= {1'b0, d_prev}) begin
            rem_in = 32'(rem_sh - {1'b0, d_prev});
            qbit   = 1'b1;
         end else begin
            rem_in = rem_sh[31:0];
            qbit   = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         dv_rem_ff[gi+1] <= rem_in;
         dv_quo_ff[gi+1] <= {quo_prev[29:0], qbit};
         dv_d_ff[gi+1]   <= d_prev;
      end
   end

   // N cos lat and N (1 - e2), then the three coordinates
   always_ff @(posedge clock) begin
      ncl_prod_ff <= 63'(dv_quo_ff[DIV_STEPS]) * 63'(mag33(pass_ff[PASS_LEN-3].clat));
      ncl_neg_ff  <= pass_ff[PASS_LEN-3].clat < 33'sd0;
      zr_prod_ff  <= 62'(dv_quo_ff[DIV_STEPS]) * 62'(ONE_MINUS_E2_Q31);

      ncl_mag_ff  <= 32'((ncl_prod_ff + 63'(ROUND_Q31)) >> 31);
      ncl_neg2_ff <= ncl_neg_ff;
      nz_ff       <= 31'((zr_prod_ff + 62'(ROUND_Q31)) >> 31);

      x_prod_ff <= 63'(ncl_mag_ff) * 63'(mag33(pass_ff[PASS_LEN-1].clon));
      x_neg_ff  <= ncl_neg2_ff ^ (pass_ff[PASS_LEN-1].clon < 33'sd0);
      y_prod_ff <= 63'(ncl_mag_ff) * 63'(mag33(pass_ff[PASS_LEN-1].slon));
      y_neg_ff  <= ncl_neg2_ff ^ (pass_ff[PASS_LEN-1].slon < 33'sd0);
      z_prod_ff <= 63'(nz_ff) * 63'(mag33(pass_ff[PASS_LEN-1].slat));
      z_neg_ff  <= pass_ff[PASS_LEN-1].slat < 33'sd0;

      pos_x_ff <= round_sat(x_prod_ff, x_neg_ff);
      pos_y_ff <= round_sat(y_prod_ff, y_neg_ff);
      pos_z_ff <= round_sat(z_prod_ff, z_neg_ff);
   end

   assign busy       = busy_ff;
   assign rsp_strobe = post_vld_ff[POST_STAGES-1];
   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_ff;
   assign rsp_pos_z  = pos_z_ff;

endmodule

// ===== hdl/gte_checker.sv =====
// Port-level checks of the geodetic to ECEF surface unit, bound to the top level.
module gte_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_latitude,
   input logic [31:0]        req_longitude,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_pos_x,
   input logic signed [31:0] rsp_pos_y,
   input logic signed [31:0] rsp_pos_z
);
   import gte_pkg::*;

   localparam logic signed [31:0] Lim = $signed(OUT_LIMIT);

   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without an item taken at the pipeline depth before");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_pos_x <= Lim && rsp_pos_x >= -Lim &&
                      rsp_pos_y <= Lim && rsp_pos_y >= -Lim &&
                      rsp_pos_z <= Lim && rsp_pos_z >= -Lim))
      else $error("coordinate outside the saturation range");

   a_equator: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(start && !busy && req_latitude == 32'sd0 &&
                          req_longitude == 32'd0, PIPE_DEPTH)
      |-> (rsp_pos_z == 32'sd0 && rsp_pos_y == 32'sd0))
      else $error("equator and prime meridian item gave non-zero y or z");

endmodule

bind geodetic_to_ecef_surface_unit gte_checker u_gte_checker (.*);
